// ===== rtl/ntchm_pkg.sv =====
// shared constants and types for the ntc temperature hysteresis monitor
`default_nettype none
package ntchm_pkg;

  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned TEMP_W   = 11;
  localparam int unsigned LEVEL_W  = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 14;

  typedef logic [SAMPLE_W-1:0]      sample_t;
  typedef logic signed [TEMP_W-1:0] temp_t;
  typedef logic [LEVEL_W-1:0]       level_t;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WARNING_ON     = 3'd0,
    REG_WARNING_OFF    = 3'd1,
    REG_DANGER_ON      = 3'd2,
    REG_DANGER_OFF     = 3'd3,
    REG_ADC_FAULT_LOW  = 3'd4,
    REG_ADC_FAULT_HIGH = 3'd5,
    REG_BETA_KELVIN    = 3'd6
  } cfg_reg_t;

  localparam level_t LEVEL_SAFE    = 2'd0;
  localparam level_t LEVEL_WARNING = 2'd1;
  localparam level_t LEVEL_DANGER  = 2'd2;
  localparam level_t LEVEL_FAULT   = 2'd3;

  localparam temp_t FAULT_TEMP = -11'sd1000;
  localparam temp_t TEMP_MAX   = 11'sd999;

  // ln(2) in q16.16
  localparam logic [15:0] LN2_Q16 = 16'd45426;
  // 273.15 in q16.16
  localparam logic [30:0] KELVIN_OFFSET_Q16 = 31'd17901158;
  // 1/298.15 in q0.40, rounded
  localparam longint unsigned INV_T0_L =
    ((64'd1 << 40) * 64'd100 + 64'd14907) / 64'd29815;
  localparam logic [46:0] INV_T0 = INV_T0_L[46:0];

endpackage
`default_nettype wire

// ===== rtl/ntchm_if.sv =====
// valid/ready stream interfaces for samples and readings
`default_nettype none
interface ntchm_in_if;
  import ntchm_pkg::*;
  logic    valid;
  logic    ready;
  sample_t adc_sample;
  modport source (output valid, output adc_sample, input ready);
  modport sink (input valid, input adc_sample, output ready);
endinterface

interface ntchm_out_if;
  import ntchm_pkg::*;
  logic   valid;
  logic   ready;
  temp_t  temperature;
  level_t level;
  modport source (output valid, output temperature, output level, input ready);
  modport sink (input valid, input temperature, input level, output ready);
endinterface
`default_nettype wire

// ===== rtl/ntc_temperature_hysteresis_monitor.sv =====
// ntc thermistor temperature monitor with hysteresis alarm levels
`default_nettype none
// usage:
//   samples  : one raw adc reading per transfer (valid/ready)
//   readings : rounded celsius and alarm level, one per sample (valid/ready)
//   cfg_*    : register writes, taken at any edge with cfg_write high,
//              issued by the user only while no sample is in flight (not enforced)
// sequence: a normal sample runs two 16-step log2 loops on the shared
//   32x32 multiplier, then a 45-step and a 29-step restoring division on
//   the shared divider; a faulted sample, a non-positive inverse
//   temperature or a kelvin value past the top of the scale ends early
// samples is ready only while the sequencer is idle, so a new sample is
//   taken only once the last one has left the sequencer
// the reading sits in an output register, so the next sample is taken
//   while a reading still waits; if the receiver stalls, the sequencer
//   holds its finished result until the output register frees up
// reset: configuration registers go to their defaults and the kept level to fault
module ntc_temperature_hysteresis_monitor #(
  parameter int unsigned ADC_BITS = 12
) (
  input  wire                                 clk,
  input  wire                                 rst,
  ntchm_in_if.sink                            samples,
  ntchm_out_if.source                         readings,
  input  wire                                 cfg_write,
  input  wire logic [ntchm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ntchm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ntchm_pkg::*;

  localparam int unsigned AW = ADC_BITS;
  localparam int unsigned CW = ((AW > SAMPLE_W) ? AW : SAMPLE_W) + 1;
  localparam int unsigned QW = 45;   // divider quotient / dividend width
  localparam int unsigned RW = 46;   // divider remainder / divisor width

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_LOG, S_LN, S_LN2, S_DIV, S_INV, S_SET2,
    S_CEL, S_ROUND, S_DONE
  } state_t;

  // configuration registers
  logic signed [7:0] warning_on, warning_off, danger_on, danger_off;
  logic [11:0]       adc_fault_low, adc_fault_high;
  logic [13:0]       beta_kelvin;

  state_t      state;
  level_t      current_level;
  logic [AW-1:0] adc;
  logic        which;          // 0: log2 of adc, 1: log2 of full-adc
  logic        div_phase;      // 0: ln/beta, 1: 2^56/invt
  logic [5:0]  cnt;
  logic [31:0] y;
  logic [3:0]  k;
  logic [15:0] frac;
  logic [19:0] log_a;
  logic [36:0] lnp;
  logic        ln_neg;
  logic [RW-1:0] rem;
  logic [QW-1:0] quot;
  logic [RW-1:0] divisor;
  logic signed [46:0] inv_t;
  logic signed [30:0] cq;
  temp_t       temp;

  logic [AW-1:0] full;
  logic [AW-1:0] adc_in;
  logic [AW-1:0] adc_b;
  logic [CW-1:0] adc_x, low_x, high_x;
  logic          sample_fault;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  // divider step
  logic [RW:0]   shifted;
  logic          take;
  logic [RW-1:0] rem_step;

  // normalizer
  logic [AW-1:0] norm_x;
  logic [3:0]    norm_k;
  logic [31:0]   norm_y;

  logic signed [21:0] d2;
  logic [20:0]        d2_mag;
  logic [37:0]        ln_sum;
  logic [20:0]        ln_mag;
  logic [45:0]        div1_n;
  logic [13:0]        beta_eff;
  logic signed [46:0] q_signed;
  logic [57:0]        n2;
  logic [30:0]        c_mag;
  logic [31:0]        c_sum;
  logic [14:0]        c_round;
  logic [9:0]         c_sat;
  level_t             nl;

  assign full = {AW{1'b1}};

  always_comb begin
    adc_in = '0;
    for (int i = 0; i < AW; i++) begin
      if (i < SAMPLE_W) begin
        adc_in[i] = samples.adc_sample[i];
      end
    end
  end

  assign adc_x  = CW'(adc);
  assign low_x  = CW'(adc_fault_low);
  assign high_x = CW'(adc_fault_high);
  assign sample_fault = (adc_x <= low_x) || (adc_x >= high_x) ||
                        (adc == '0) || (adc == full);

  assign adc_b  = full - adc;
  assign norm_x = which ? adc_b : adc;

  // top set bit and shift into q1.31
  always_comb begin
    norm_k = '0;
    for (int i = 0; i < AW; i++) begin
      if (norm_x[i]) begin
        norm_k = 4'(i);
      end
    end
    norm_y = 32'(norm_x) << (5'd31 - {1'b0, norm_k});
  end

  assign d2     = signed'({2'b00, log_a}) - signed'({2'b00, k, frac});
  assign d2_mag = d2[21] ? 21'(-d2) : d2[20:0];

  always_comb begin
    if (state == S_LN) begin
      mul_a = 32'(d2_mag);
      mul_b = 32'(LN2_Q16);
    end else begin
      mul_a = y;
      mul_b = y;
    end
    prod = mul_a * mul_b;
  end

  assign ln_sum   = {1'b0, lnp} + 38'd32768;
  assign ln_mag   = ln_sum[36:16];
  assign beta_eff = (beta_kelvin == '0) ? 14'd1 : beta_kelvin;
  assign div1_n   = {ln_mag[20:0], 24'd0} + 46'(beta_eff[13:1]);

  assign shifted  = {rem, quot[QW-1]};
  assign take     = shifted >= {1'b0, divisor};
  assign rem_step = take ? RW'(shifted - {1'b0, divisor}) : shifted[RW-1:0];

  assign q_signed = ln_neg ? -signed'({2'b00, quot}) : signed'({2'b00, quot});
  assign n2       = (58'd1 << 56) + 58'(inv_t[45:1]);

  assign c_mag   = cq[30] ? 31'(-cq) : cq;
  assign c_sum   = {1'b0, c_mag} + 32'd32768;
  assign c_round = c_sum[30:16];
  assign c_sat   = (c_round > 15'd999) ? 10'd999 : c_round[9:0];

  // hysteresis on the kept level
  always_comb begin
    if (temp <= FAULT_TEMP) begin
      nl = LEVEL_FAULT;
    end else begin
      case (current_level)
        LEVEL_WARNING: begin
          if (temp >= TEMP_W'(danger_on)) nl = LEVEL_DANGER;
          else if (temp <= TEMP_W'(warning_off)) nl = LEVEL_SAFE;
          else nl = LEVEL_WARNING;
        end
        LEVEL_DANGER: begin
          if (temp <= TEMP_W'(danger_off)) begin
            nl = (temp <= TEMP_W'(warning_off)) ? LEVEL_SAFE : LEVEL_WARNING;
          end else begin
            nl = LEVEL_DANGER;
          end
        end
        default: begin
          if (temp >= TEMP_W'(danger_on)) nl = LEVEL_DANGER;
          else if (temp >= TEMP_W'(warning_on)) nl = LEVEL_WARNING;
          else nl = LEVEL_SAFE;
        end
      endcase
    end
  end

  assign samples.ready = (state == S_IDLE);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      warning_on     <= 8'sd45;
      warning_off    <= 8'sd42;
      danger_on      <= 8'sd55;
      danger_off     <= 8'sd52;
      adc_fault_low  <= 12'd3;
      adc_fault_high <= 12'd4092;
      beta_kelvin    <= 14'd3976;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WARNING_ON:     warning_on     <= cfg_data[7:0];
        REG_WARNING_OFF:    warning_off    <= cfg_data[7:0];
        REG_DANGER_ON:      danger_on      <= cfg_data[7:0];
        REG_DANGER_OFF:     danger_off     <= cfg_data[7:0];
        REG_ADC_FAULT_LOW:  adc_fault_low  <= cfg_data[11:0];
        REG_ADC_FAULT_HIGH: adc_fault_high <= cfg_data[11:0];
        REG_BETA_KELVIN:    beta_kelvin    <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      current_level  <= LEVEL_FAULT;
      readings.valid <= 1'b0;
    end else begin
      // the done state loads the output register itself
      if (readings.valid && readings.ready && state != S_DONE) begin
        readings.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (samples.valid) begin
            adc   <= adc_in;
            which <= 1'b0;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (sample_fault) begin
            temp  <= FAULT_TEMP;
            state <= S_DONE;
          end else begin
            y     <= norm_y;
            k     <= norm_k;
            frac  <= '0;
            cnt   <= 6'd16;
            state <= S_LOG;
          end
        end
        S_LOG: begin
          // square the mantissa, one fraction bit per step
          if (prod[63]) begin
            y    <= prod[63:32];
            frac <= {frac[14:0], 1'b1};
          end else begin
            y    <= prod[62:31];
            frac <= {frac[14:0], 1'b0};
          end
          cnt <= cnt - 6'd1;
          if (cnt == 6'd1) begin
            state <= which ? S_LN : S_CHECK;
            if (!which) begin
              log_a <= {k, frac[14:0], prod[63]};
              which <= 1'b1;
            end
          end
        end
        S_LN: begin
          lnp    <= prod[36:0];
          ln_neg <= d2[21];
          state  <= S_LN2;
        end
        S_LN2: begin
          rem       <= '0;
          quot      <= div1_n[QW-1:0];
          divisor   <= RW'(beta_eff);
          cnt       <= 6'(QW);
          div_phase <= 1'b0;
          state     <= S_DIV;
        end
        S_DIV: begin
          rem  <= rem_step;
          quot <= {quot[QW-2:0], take};
          cnt  <= cnt - 6'd1;
          if (cnt == 6'd1) begin
            state <= div_phase ? S_CEL : S_INV;
          end
        end
        S_INV: begin
          inv_t <= signed'(INV_T0) + q_signed;
          state <= S_SET2;
        end
        S_SET2: begin
          if (inv_t[46] || inv_t == '0) begin
            temp  <= FAULT_TEMP;
            state <= S_DONE;
          end else if (RW'(n2[57:29]) >= inv_t[45:0]) begin
            // kelvin at or past 2^13, far above the top of the scale
            temp  <= TEMP_MAX;
            state <= S_DONE;
          end else begin
            rem       <= RW'(n2[57:29]);
            quot      <= {n2[28:0], 16'd0};
            divisor   <= inv_t[45:0];
            cnt       <= 6'd29;
            div_phase <= 1'b1;
            state     <= S_DIV;
          end
        end
        S_CEL: begin
          cq    <= signed'({2'b00, quot[28:0]}) - signed'(KELVIN_OFFSET_Q16);
          state <= S_ROUND;
        end
        S_ROUND: begin
          temp  <= cq[30] ? -signed'({1'b0, c_sat}) : signed'({1'b0, c_sat});
          state <= S_DONE;
        end
        S_DONE: begin
          if (!readings.valid || readings.ready) begin
            readings.valid       <= 1'b1;
            readings.temperature <= temp;
            readings.level       <= nl;
            current_level        <= nl;
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
